>>> rtl/ess_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exclusive sequence scanner package
// Beat types, status codes, access families and the instruction decoders.
// ----------------------------------------------------------------------------
package ess_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] start_pc;
        logic [31:0] status_word;
        logic [31:0] code_word;
        logic        first_read_ok;
        logic        second_read_ok;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] fetch_address;
        logic [31:0] target_address;
        logic [2:0]  bkpt_len;
        logic [6:0]  instr_used;
        logic [8:0]  bytes_used;
    } out_beat_t;

    localparam logic [1:0] ST_CONTINUE = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_FAIL     = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic [1:0] K_OTHER = 2'd0;
    localparam logic [1:0] K_LOAD  = 2'd1;
    localparam logic [1:0] K_STORE = 2'd2;
    localparam logic [1:0] K_CLEAR = 2'd3;

    localparam logic [2:0] FAM_NONE   = 3'd0;
    localparam logic [2:0] FAM_WORD   = 3'd1;
    localparam logic [2:0] FAM_BYTE   = 3'd2;
    localparam logic [2:0] FAM_HALF   = 3'd3;
    localparam logic [2:0] FAM_DOUBLE = 3'd4;

    localparam logic       REQ_START = 1'b0;
    localparam logic [0:0] REG_INSTRUCTION_LIMIT = 1'b0;
    localparam logic [0:0] REG_BYTE_LIMIT        = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] fam;
        logic [3:0] base;
        logic [3:0] cond;
        logic       ok;
    } excl_t;

    function automatic logic cond_ok(input logic [3:0] c, input logic [3:0] f);
        logic p;
        p = 1'b0;
        case (c[3:1])
            3'd0: p = f[2];
            3'd1: p = f[1];
            3'd2: p = f[3];
            3'd3: p = f[0];
            3'd4: p = f[1] & ~f[2];
            3'd5: p = f[3] == f[0];
            3'd6: p = ~f[2] & (f[3] == f[0]);
            default: p = (c == 4'he);
        endcase
        return (c == 4'hf) ? 1'b0 : (c[0] ? ~p : p);
    endfunction

    function automatic logic arm_writes_pc(input logic [31:0] w);
        logic nc;
        logic [31:0] lo;
        logic [2:0] op;
        logic r;
        nc = w[31:28] != 4'hf;
        lo = w & 32'h0ffffff0;
        op = w[27:25];
        r = ((w & 32'hfe50ffff) == 32'hf8100a00)
            || (nc && (w & 32'h0fffffff) == 32'h0160006e)
            || ((w & 32'hfe000000) == 32'hfa000000)
            || (nc && (w & 32'h0e000000) == 32'h0a000000)
            || (nc && (lo == 32'h012fff10 || lo == 32'h012fff20 || lo == 32'h012fff30))
            || (nc && (w & 32'h0e100000) == 32'h08100000 && w[15])
            || (nc && (w & 32'h0c10f000) == 32'h0410f000)
            || (nc && w[15:12] == 4'hf
                && (op == 3'd1 || (op == 3'd0 && (!w[4] || !w[7]))));
        return r;
    endfunction

    function automatic logic arm_blocks(input logic [31:0] w);
        logic [27:0] m;
        m = w[27:0];
        return (w[31:28] != 4'hf && w[27:24] == 4'hf)
            || m == 28'h320f002 || m == 28'h320f003;
    endfunction

    function automatic excl_t arm_decode(input logic [31:0] w);
        excl_t d;
        logic [31:0] ls;
        logic [31:0] ss;
        logic [3:0] rn;
        logic [3:0] rt;
        logic [3:0] rs;
        ls = w & 32'h0ff00fff;
        ss = w & 32'h0ff00ff0;
        rn = w[19:16];
        rt = w[15:12];
        rs = w[3:0];
        d = '{kind: K_OTHER, fam: FAM_NONE, base: 4'd0, cond: w[31:28], ok: 1'b0};
        if (w == 32'hf57ff01f) begin
            d.kind = K_CLEAR;
            d.ok = 1'b1;
        end else if (ls == 32'h01900f9f || ls == 32'h01d00f9f || ls == 32'h01f00f9f
                     || ls == 32'h01b00f9f) begin
            d.kind = K_LOAD;
            d.base = rn;
            d.fam = (ls == 32'h01900f9f) ? FAM_WORD : (ls == 32'h01d00f9f) ? FAM_BYTE :
                    (ls == 32'h01f00f9f) ? FAM_HALF : FAM_DOUBLE;
            d.ok = d.cond != 4'hf && rn != 4'hf && rt != 4'hf
                   && (d.fam != FAM_DOUBLE || (!rt[0] && rt != 4'he));
        end else if (ss == 32'h01800f90 || ss == 32'h01c00f90 || ss == 32'h01e00f90
                     || ss == 32'h01a00f90) begin
            d.kind = K_STORE;
            d.base = rn;
            d.fam = (ss == 32'h01800f90) ? FAM_WORD : (ss == 32'h01c00f90) ? FAM_BYTE :
                    (ss == 32'h01e00f90) ? FAM_HALF : FAM_DOUBLE;
            d.ok = d.cond != 4'hf && rn != 4'hf && rt != 4'hf && rs != 4'hf
                   && rt != rn && rt != rs;
            if (d.fam == FAM_DOUBLE) begin
                d.ok = d.ok && !rs[0] && rs != 4'he && {1'b0, rt} != {1'b0, rs} + 5'd1;
            end
        end
        return d;
    endfunction

    function automatic logic t16_writes_pc(input logic [15:0] a);
        logic r;
        r = (a[15:12] == 4'hd && a[11:8] < 4'he) || (a & 16'hf800) == 16'he000
            || (a & 16'hff07) == 16'h4700 || a[15:8] == 8'hbd
            || (a & 16'hf500) == 16'hb100;
        if (a[15:8] == 8'h44 || a[15:8] == 8'h46) begin
            r = r || {a[7], a[2:0]} == 4'hf;
        end
        return r;
    endfunction

    function automatic logic t32_writes_pc(input logic [15:0] a, input logic [15:0] b);
        logic r;
        r = ((a & 16'hf800) == 16'hf000 && b[15]
             && (b[12] || (b & 16'hd001) == 16'hc000
                 || ((b & 16'hd000) == 16'h8000 && a[9:7] != 3'b111)))
            || ((a & 16'hfff0) == 16'he8d0 && (b & 16'hffe0) == 16'hf000)
            || ((a & 16'hfe50) == 16'he810 && (a[7] == a[8] || b[15]))
            || ((a & 16'hff70) == 16'hf850 && b[15:12] == 4'hf)
            || ((a & 16'hffef) == 16'hea4f && (b & 16'hfff0) == 16'h0f00)
            || ((a & 16'hfff0) == 16'hf3c0 && b == 16'h8f00)
            || (a == 16'hf3de && b[15:8] == 8'h8f);
        return r;
    endfunction

    function automatic logic t_blocks(input logic [15:0] a, input logic [15:0] b);
        return a[15:8] == 8'hdf || a == 16'hbf20 || a == 16'hbf30
            || (a == 16'hf3af && (b == 16'h8002 || b == 16'h8003));
    endfunction

    function automatic excl_t t_decode(input logic [15:0] a, input logic [15:0] b);
        excl_t d;
        logic [3:0] rn;
        logic [3:0] rt;
        logic [3:0] rt2;
        logic [3:0] rd;
        rn = a[3:0];
        rt = b[15:12];
        rt2 = b[11:8];
        rd = b[3:0];
        d = '{kind: K_OTHER, fam: FAM_NONE, base: 4'd0, cond: 4'he, ok: 1'b0};
        if (a == 16'hf3bf && b == 16'h8f2f) begin
            d.kind = K_CLEAR;
            d.ok = 1'b1;
        end else if (a[15:4] == 12'he85 && b[11:8] == 4'hf) begin
            d.kind = K_LOAD;
            d.fam = FAM_WORD;
            d.base = rn;
            d.ok = rn != 4'hf && rt != 4'hd && rt != 4'hf;
        end else if (a[15:4] == 12'he8d) begin
            if (b[11:0] == 12'hf4f) d.fam = FAM_BYTE;
            else if (b[11:0] == 12'hf5f) d.fam = FAM_HALF;
            else if (b[7:0] == 8'h7f) d.fam = FAM_DOUBLE;
            if (d.fam != FAM_NONE) begin
                d.kind = K_LOAD;
                d.base = rn;
                d.ok = rn != 4'hf && rt != 4'hd && rt != 4'hf;
                if (d.fam == FAM_DOUBLE) begin
                    d.ok = d.ok && rt2 != 4'hd && rt2 != 4'hf && rt != rt2;
                end
            end
        end else if (a[15:4] == 12'he84) begin
            d.kind = K_STORE;
            d.fam = FAM_WORD;
            d.base = rn;
            d.ok = rn != 4'hf && rt != 4'hd && rt != 4'hf && rt2 != 4'hd && rt2 != 4'hf
                   && rt2 != rn && rt2 != rt;
        end else if (a[15:4] == 12'he8c) begin
            if (b[11:4] == 8'hf4) d.fam = FAM_BYTE;
            else if (b[11:4] == 8'hf5) d.fam = FAM_HALF;
            else if (b[7:4] == 4'h7) d.fam = FAM_DOUBLE;
            if (d.fam != FAM_NONE) begin
                d.kind = K_STORE;
                d.base = rn;
                d.ok = rn != 4'hf && rt != 4'hd && rt != 4'hf && rd != 4'hd && rd != 4'hf
                       && rd != rn && rd != rt;
                if (d.fam == FAM_DOUBLE) begin
                    d.ok = d.ok && rt2 != 4'hd && rt2 != 4'hf && rt != rt2 && rd != rt2;
                end
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ess_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exclusive sequence scanner instruction classifier
// Classifies one fetched ARM or Thumb instruction for the scan sequencer.
// ----------------------------------------------------------------------------
module ess_decode (
    input  wire logic           thumb,
    input  wire logic [31:0]    code_word,
    output ess_pkg::excl_t      dec,
    output logic                wide,
    output logic                forbidden
);

    logic [15:0] a;
    logic [15:0] b;

    assign a = code_word[15:0];
    assign b = wide ? code_word[31:16] : 16'd0;
    assign wide = thumb ? (a[15:11] >= 5'h1d) : 1'b1;

    always_comb begin
        if (!thumb) begin
            dec = ess_pkg::arm_decode(code_word);
            forbidden = ess_pkg::arm_writes_pc(code_word) || ess_pkg::arm_blocks(code_word);
        end else begin
            if (wide) begin
                dec = ess_pkg::t_decode(a, b);
            end else begin
                dec = '{kind: ess_pkg::K_OTHER, fam: ess_pkg::FAM_NONE, base: 4'd0,
                        cond: 4'he, ok: 1'b0};
            end
            forbidden = (a[15:8] == 8'hbf && a[3:0] != 4'd0) || ess_pkg::t_blocks(a, b)
                        || (wide ? ess_pkg::t32_writes_pc(a, b) : ess_pkg::t16_writes_pc(a));
        end
    end

endmodule
`default_nettype wire

>>> rtl/exclusive_sequence_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Exclusive sequence scanner
// A beat is registered on accept; its result beat is then registered at the output.
// Throughput: one beat per cycle with the skid stage empty; state updates per beat.
// The result sits in an output register with a skid stage behind it.
// Reset clears the scan state and loads the limits with 64 and 256.
// ----------------------------------------------------------------------------
module exclusive_sequence_scanner #(
    parameter int MAX_INSTRUCTIONS = 64,
    parameter int MAX_BYTES = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ess_pkg::in_beat_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ess_pkg::out_beat_t       m_data,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [8:0]          cfg_data
);

    logic [6:0] ilim_reg;
    logic [8:0] blim_reg;
    logic active_reg;
    logic thumb_reg;
    logic [3:0] flags_reg;
    logic [31:0] pc_reg;
    logic [2:0] fam_reg;
    logic [3:0] base_reg;
    logic [6:0] icnt_reg;
    logic [8:0] bcnt_reg;

    logic in_valid_reg;
    ess_pkg::in_beat_t in_reg;
    logic out_valid_reg;
    ess_pkg::out_beat_t out_reg;
    logic skid_valid_reg;
    ess_pkg::out_beat_t skid_reg;

    logic active_next;
    logic thumb_next;
    logic [3:0] flags_next;
    logic [31:0] pc_next;
    logic [2:0] fam_next;
    logic [3:0] base_next;
    logic [6:0] icnt_next;
    logic [8:0] bcnt_next;
    ess_pkg::out_beat_t res;

    ess_pkg::excl_t dec;
    logic wide;
    logic forbidden;

    ess_decode u_dec (
        .thumb     (thumb_reg),
        .code_word (in_reg.code_word),
        .dec       (dec),
        .wide      (wide),
        .forbidden (forbidden)
    );

    logic work;
    assign work = in_valid_reg && !skid_valid_reg;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_comb begin
        logic [7:0] it;
        logic [9:0] bsum2;
        logic [9:0] bsize;
        logic [2:0] size;
        logic [6:0] ic;
        logic [32:0] pcend;
        logic st_ok;
        it = {in_reg.status_word[15:10], in_reg.status_word[26:25]};
        active_next = active_reg;
        thumb_next = thumb_reg;
        flags_next = flags_reg;
        pc_next = pc_reg;
        fam_next = fam_reg;
        base_next = base_reg;
        icnt_next = icnt_reg;
        bcnt_next = bcnt_reg;
        res = '0;
        bsum2 = {1'b0, bcnt_reg} + 10'd2;
        size = wide ? 3'd4 : 3'd2;
        bsize = {1'b0, bcnt_reg} + {7'd0, size};
        ic = icnt_reg + 7'd1;
        pcend = {1'b0, pc_reg} + {30'd0, size};
        st_ok = 1'b0;
        if (in_reg.req_type == ess_pkg::REQ_START) begin
            active_next = 1'b0;
            icnt_next = '0;
            bcnt_next = '0;
            fam_next = ess_pkg::FAM_NONE;
            base_next = '0;
            if (ilim_reg == 7'd0 || 32'(ilim_reg) > 32'(MAX_INSTRUCTIONS)
                || blim_reg == 9'd0 || 32'(blim_reg) > 32'(MAX_BYTES)
                || in_reg.status_word[24] || in_reg.status_word[9]
                || (in_reg.status_word[5] && (in_reg.start_pc[0] || it != 8'd0))
                || (!in_reg.status_word[5] && in_reg.start_pc[1:0] != 2'd0)) begin
                res.status = ess_pkg::ST_FAIL;
            end else begin
                active_next = 1'b1;
                thumb_next = in_reg.status_word[5];
                flags_next = in_reg.status_word[31:28];
                pc_next = in_reg.start_pc;
                res.status = ess_pkg::ST_CONTINUE;
                res.fetch_address = in_reg.start_pc;
            end
            res.instr_used = '0;
            res.bytes_used = '0;
        end else if (!active_reg) begin
            res.status = ess_pkg::ST_IGNORED;
        end else begin
            res.instr_used = icnt_reg;
            res.bytes_used = bcnt_reg;
            res.status = ess_pkg::ST_FAIL;
            if ((thumb_reg && bsum2 > {1'b0, blim_reg}) || bsize > {1'b0, blim_reg}
                || !in_reg.first_read_ok
                || (thumb_reg && wide && (pc_reg > 32'hfffffffd || !in_reg.second_read_ok)))
                begin
                res.status = ess_pkg::ST_FAIL;
            end else begin
                icnt_next = ic;
                bcnt_next = bsize[8:0];
                res.instr_used = ic;
                res.bytes_used = bsize[8:0];
                if (icnt_reg == 7'd0) begin
                    if (dec.kind == ess_pkg::K_LOAD && dec.ok
                        && (thumb_reg || ess_pkg::cond_ok(dec.cond, flags_reg))) begin
                        fam_next = dec.fam;
                        base_next = dec.base;
                        st_ok = 1'b1;
                    end
                end else if (dec.kind == ess_pkg::K_STORE || dec.kind == ess_pkg::K_CLEAR)
                    begin
                    if ((dec.kind == ess_pkg::K_CLEAR
                         || (dec.ok && (thumb_reg || dec.cond == 4'he)
                             && dec.fam == fam_reg && dec.base == base_reg))
                        && !pcend[32]) begin
                        res.status = ess_pkg::ST_FOUND;
                        res.target_address = pcend[31:0];
                        res.bkpt_len = thumb_reg ? 3'd2 : 3'd4;
                    end
                end else if (dec.kind == ess_pkg::K_OTHER && !forbidden) begin
                    st_ok = 1'b1;
                end
                if (st_ok && !pcend[32]) begin
                    pc_next = pcend[31:0];
                    if (32'(ic) < 32'(ilim_reg)) begin
                        res.status = ess_pkg::ST_CONTINUE;
                        res.fetch_address = pcend[31:0];
                    end
                end
            end
            if (res.status == ess_pkg::ST_FOUND || res.status == ess_pkg::ST_FAIL) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ilim_reg <= 7'd64;
            blim_reg <= 9'd256;
            active_reg <= 1'b0;
            thumb_reg <= 1'b0;
            flags_reg <= '0;
            pc_reg <= '0;
            fam_reg <= ess_pkg::FAM_NONE;
            base_reg <= '0;
            icnt_reg <= '0;
            bcnt_reg <= '0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == ess_pkg::REG_INSTRUCTION_LIMIT) ilim_reg <= cfg_data[6:0];
                else blim_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
                if (s_valid) in_reg <= s_data;
            end
            if (work) begin
                active_reg <= active_next;
                thumb_reg <= thumb_next;
                flags_reg <= flags_next;
                pc_reg <= pc_next;
                fam_reg <= fam_next;
                base_reg <= base_next;
                icnt_reg <= icnt_next;
                bcnt_reg <= bcnt_next;
            end
            if (!out_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_reg <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= work;
                    out_reg <= res;
                end
            end else if (work) begin
                skid_valid_reg <= 1'b1;
                skid_reg <= res;
            end
        end
    end

    a_skid_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without a stalled output");
    a_ignored_counts_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ess_pkg::ST_IGNORED) |->
        (m_data.instr_used == 7'd0 && m_data.bytes_used == 9'd0))
        else $error("ignored beat carries counts");
    a_found_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ess_pkg::ST_FOUND) |->
        (m_data.bkpt_len == 3'd2 || m_data.bkpt_len == 3'd4))
        else $error("bad breakpoint size");

endmodule
`default_nettype wire

>>> dv/exclusive_sequence_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exclusive sequence scanner testbench
// Drives start and fetch beats with random gaps and output stalls, predicts
// each result beat with an independent scan model and checks it in order.
// ----------------------------------------------------------------------------
module exclusive_sequence_scanner_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEM_TARGET = 1700;
    localparam int IN_W = $bits(ess_pkg::in_beat_t);

    class scan_scoreboard;
        logic [6:0] ilim;
        logic [8:0] blim;
        bit active;
        bit thumb;
        logic [3:0] flags;
        logic [31:0] pc;
        logic [2:0] fam;
        logic [3:0] base;
        int unsigned icnt;
        int unsigned bcnt;
        ess_pkg::out_beat_t pending[$];
        int errors;
        int found_cnt;
        int fail_cnt;
        int cont_cnt;

        function new();
            ilim = 7'd64;
            blim = 9'd256;
            active = 0;
            thumb = 0;
            flags = 0;
            pc = 0;
            fam = ess_pkg::FAM_NONE;
            base = 0;
            icnt = 0;
            bcnt = 0;
            errors = 0;
            found_cnt = 0;
            fail_cnt = 0;
            cont_cnt = 0;
        endfunction

        function bit cond_pass(logic [3:0] c);
            bit n, z, cy, v, p;
            n = flags[3];
            z = flags[2];
            cy = flags[1];
            v = flags[0];
            if (c == 4'hf) return 0;
            case (c[3:1])
                0: p = z;
                1: p = cy;
                2: p = n;
                3: p = v;
                4: p = cy && !z;
                5: p = n == v;
                6: p = !z && n == v;
                default: p = (c == 4'he);
            endcase
            return c[0] ? !p : p;
        endfunction

        function bit arm_pc_write(logic [31:0] w);
            bit nc;
            logic [31:0] lo;
            logic [2:0] op;
            nc = w[31:28] != 4'hf;
            lo = w & 32'h0ffffff0;
            op = w[27:25];
            if ((w & 32'hfe50ffff) == 32'hf8100a00) return 1;
            if (nc && (w & 32'h0fffffff) == 32'h0160006e) return 1;
            if ((w & 32'hfe000000) == 32'hfa000000) return 1;
            if (nc && (w & 32'h0e000000) == 32'h0a000000) return 1;
            if (nc && (lo == 32'h012fff10 || lo == 32'h012fff20 || lo == 32'h012fff30))
                return 1;
            if (nc && (w & 32'h0e100000) == 32'h08100000 && w[15]) return 1;
            if (nc && (w & 32'h0c10f000) == 32'h0410f000) return 1;
            if (nc && w[15:12] == 4'hf && (op == 1 || (op == 0 && (!w[4] || !w[7]))))
                return 1;
            return 0;
        endfunction

        function bit arm_block(logic [31:0] w);
            return (w[31:28] != 4'hf && w[27:24] == 4'hf) ||
                   w[27:0] == 28'h320f002 || w[27:0] == 28'h320f003;
        endfunction

        function ess_pkg::excl_t arm_dec(logic [31:0] w);
            ess_pkg::excl_t d;
            logic [31:0] ls, ss;
            logic [3:0] rn, rt, rs;
            ls = w & 32'h0ff00fff;
            ss = w & 32'h0ff00ff0;
            rn = w[19:16];
            rt = w[15:12];
            rs = w[3:0];
            d = '{kind: ess_pkg::K_OTHER, fam: ess_pkg::FAM_NONE, base: 0, cond: w[31:28],
                  ok: 0};
            if (w == 32'hf57ff01f) begin
                d.kind = ess_pkg::K_CLEAR;
                d.ok = 1;
                return d;
            end
            case (ls)
                32'h01900f9f: d.fam = ess_pkg::FAM_WORD;
                32'h01d00f9f: d.fam = ess_pkg::FAM_BYTE;
                32'h01f00f9f: d.fam = ess_pkg::FAM_HALF;
                32'h01b00f9f: d.fam = ess_pkg::FAM_DOUBLE;
                default: d.fam = ess_pkg::FAM_NONE;
            endcase
            if (d.fam != ess_pkg::FAM_NONE) begin
                d.kind = ess_pkg::K_LOAD;
                d.base = rn;
                d.ok = d.cond != 4'hf && rn != 15 && rt != 15 &&
                       (d.fam != ess_pkg::FAM_DOUBLE || (!rt[0] && rt != 14));
                return d;
            end
            case (ss)
                32'h01800f90: d.fam = ess_pkg::FAM_WORD;
                32'h01c00f90: d.fam = ess_pkg::FAM_BYTE;
                32'h01e00f90: d.fam = ess_pkg::FAM_HALF;
                32'h01a00f90: d.fam = ess_pkg::FAM_DOUBLE;
                default: d.fam = ess_pkg::FAM_NONE;
            endcase
            if (d.fam != ess_pkg::FAM_NONE) begin
                d.kind = ess_pkg::K_STORE;
                d.base = rn;
                d.ok = d.cond != 4'hf && rn != 15 && rt != 15 && rs != 15 &&
                       rt != rn && rt != rs;
                if (d.fam == ess_pkg::FAM_DOUBLE)
                    d.ok = d.ok && !rs[0] && rs != 14 && int'(rt) != int'(rs) + 1;
            end
            return d;
        endfunction

        function bit t16_pc_write(logic [15:0] a);
            if ((a[15:12] == 4'hd && a[11:8] < 4'he) || a[15:11] == 5'b11100 ||
                (a & 16'hff07) == 16'h4700 || a[15:8] == 8'hbd ||
                (a & 16'hf500) == 16'hb100)
                return 1;
            if (a[15:8] == 8'h44 || a[15:8] == 8'h46) return {a[7], a[2:0]} == 4'hf;
            return 0;
        endfunction

        function bit t32_pc_write(logic [15:0] a, logic [15:0] b);
            if (a[15:11] == 5'b11110 && b[15] &&
                (b[12] || (b & 16'hd001) == 16'hc000 ||
                 ((b & 16'hd000) == 16'h8000 && a[9:7] != 3'b111)))
                return 1;
            if (a[15:4] == 12'he8d && b[15:5] == 11'b11110000000) return 1;
            if ((a & 16'hfe50) == 16'he810 && (a[7] == a[8] || b[15])) return 1;
            if ((a & 16'hff70) == 16'hf850 && b[15:12] == 4'hf) return 1;
            if ((a & 16'hffef) == 16'hea4f && b[15:4] == 12'h0f0) return 1;
            if (a[15:4] == 12'hf3c && b == 16'h8f00) return 1;
            if (a == 16'hf3de && b[15:8] == 8'h8f) return 1;
            return 0;
        endfunction

        function bit t_block(logic [15:0] a, logic [15:0] b);
            return a[15:8] == 8'hdf || a == 16'hbf20 || a == 16'hbf30 ||
                   (a == 16'hf3af && (b == 16'h8002 || b == 16'h8003));
        endfunction

        function ess_pkg::excl_t t_dec(logic [15:0] a, logic [15:0] b);
            ess_pkg::excl_t d;
            logic [3:0] rn, rt, rt2, rd;
            rn = a[3:0];
            rt = b[15:12];
            rt2 = b[11:8];
            rd = b[3:0];
            d = '{kind: ess_pkg::K_OTHER, fam: ess_pkg::FAM_NONE, base: 0, cond: 4'he,
                  ok: 0};
            if (a == 16'hf3bf && b == 16'h8f2f) begin
                d.kind = ess_pkg::K_CLEAR;
                d.ok = 1;
            end else if (a[15:4] == 12'he85 && rt2 == 4'hf) begin
                d.kind = ess_pkg::K_LOAD;
                d.fam = ess_pkg::FAM_WORD;
                d.base = rn;
                d.ok = rn != 15 && rt != 13 && rt != 15;
            end else if (a[15:4] == 12'he8d) begin
                if (b[11:0] == 12'hf4f) d.fam = ess_pkg::FAM_BYTE;
                else if (b[11:0] == 12'hf5f) d.fam = ess_pkg::FAM_HALF;
                else if (b[7:0] == 8'h7f) d.fam = ess_pkg::FAM_DOUBLE;
                if (d.fam != ess_pkg::FAM_NONE) begin
                    d.kind = ess_pkg::K_LOAD;
                    d.base = rn;
                    d.ok = rn != 15 && rt != 13 && rt != 15;
                    if (d.fam == ess_pkg::FAM_DOUBLE)
                        d.ok = d.ok && rt2 != 13 && rt2 != 15 && rt != rt2;
                end
            end else if (a[15:4] == 12'he84) begin
                d.kind = ess_pkg::K_STORE;
                d.fam = ess_pkg::FAM_WORD;
                d.base = rn;
                d.ok = rn != 15 && rt != 13 && rt != 15 && rt2 != 13 && rt2 != 15 &&
                       rt2 != rn && rt2 != rt;
            end else if (a[15:4] == 12'he8c) begin
                if (b[11:4] == 8'hf4) d.fam = ess_pkg::FAM_BYTE;
                else if (b[11:4] == 8'hf5) d.fam = ess_pkg::FAM_HALF;
                else if (b[7:4] == 4'h7) d.fam = ess_pkg::FAM_DOUBLE;
                if (d.fam != ess_pkg::FAM_NONE) begin
                    d.kind = ess_pkg::K_STORE;
                    d.base = rn;
                    d.ok = rn != 15 && rt != 13 && rt != 15 && rd != 13 && rd != 15 &&
                           rd != rn && rd != rt;
                    if (d.fam == ess_pkg::FAM_DOUBLE)
                        d.ok = d.ok && rt2 != 13 && rt2 != 15 && rt != rt2 && rd != rt2;
                end
            end
            return d;
        endfunction

        function void post(logic [1:0] st, logic [31:0] fa, logic [31:0] ta, logic [2:0] bs);
            ess_pkg::out_beat_t r;
            if (st == ess_pkg::ST_FOUND || st == ess_pkg::ST_FAIL) active = 0;
            r.status = st;
            r.fetch_address = fa;
            r.target_address = ta;
            r.bkpt_len = bs;
            r.instr_used = (st == ess_pkg::ST_IGNORED) ? 7'd0 : icnt[6:0];
            r.bytes_used = (st == ess_pkg::ST_IGNORED) ? 9'd0 : bcnt[8:0];
            pending.push_back(r);
        endfunction

        function void note_beat(ess_pkg::in_beat_t x);
            logic [15:0] a, b;
            int unsigned sz;
            logic [31:0] lim;
            logic [7:0] itb;
            ess_pkg::excl_t d;
            b = 0;
            if (x.req_type == ess_pkg::REQ_START) begin
                itb = {x.status_word[15:10], x.status_word[26:25]};
                active = 0;
                icnt = 0;
                bcnt = 0;
                fam = ess_pkg::FAM_NONE;
                base = 0;
                if (ilim == 0 || ilim > 64 || blim == 0 || blim > 256 ||
                    x.status_word[24] || x.status_word[9] ||
                    (x.status_word[5] && (x.start_pc[0] || itb != 0)) ||
                    (!x.status_word[5] && x.start_pc[1:0] != 0)) begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
                active = 1;
                thumb = x.status_word[5];
                flags = x.status_word[31:28];
                pc = x.start_pc;
                post(ess_pkg::ST_CONTINUE, pc, 0, 0);
                return;
            end
            if (!active) begin
                post(ess_pkg::ST_IGNORED, 0, 0, 0);
                return;
            end
            a = x.code_word[15:0];
            if (!thumb) begin
                if (bcnt + 4 > blim || !x.first_read_ok) begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
                sz = 4;
                d = arm_dec(x.code_word);
            end else begin
                if (bcnt + 2 > blim || !x.first_read_ok) begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
                sz = (a[15:11] >= 5'h1d) ? 4 : 2;
                if (sz == 4) begin
                    if (bcnt + 4 > blim || pc > 32'hfffffffd || !x.second_read_ok) begin
                        post(ess_pkg::ST_FAIL, 0, 0, 0);
                        return;
                    end
                    b = x.code_word[31:16];
                    d = t_dec(a, b);
                end else begin
                    d = '{kind: ess_pkg::K_OTHER, fam: ess_pkg::FAM_NONE, base: 0,
                          cond: 4'he, ok: 0};
                end
            end
            icnt++;
            bcnt += sz;
            lim = 32'hffffffff - sz;
            if (icnt == 1) begin
                if (d.kind != ess_pkg::K_LOAD || !d.ok || (!thumb && !cond_pass(d.cond)))
                    begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
                fam = d.fam;
                base = d.base;
            end else if (d.kind == ess_pkg::K_LOAD) begin
                post(ess_pkg::ST_FAIL, 0, 0, 0);
                return;
            end else if (d.kind == ess_pkg::K_STORE || d.kind == ess_pkg::K_CLEAR) begin
                if (d.kind == ess_pkg::K_STORE && (!d.ok || (!thumb && d.cond != 4'he) ||
                    d.fam != fam || d.base != base))
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                else if (pc > lim) post(ess_pkg::ST_FAIL, 0, 0, 0);
                else post(ess_pkg::ST_FOUND, 0, pc + sz, thumb ? 3'd2 : 3'd4);
                return;
            end else if (!thumb) begin
                if (arm_pc_write(x.code_word) || arm_block(x.code_word)) begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
            end else begin
                if ((a[15:8] == 8'hbf && a[3:0] != 0) || t_block(a, b) ||
                    (sz == 2 ? t16_pc_write(a) : t32_pc_write(a, b))) begin
                    post(ess_pkg::ST_FAIL, 0, 0, 0);
                    return;
                end
            end
            if (pc > lim) begin
                post(ess_pkg::ST_FAIL, 0, 0, 0);
                return;
            end
            pc += sz;
            if (icnt >= ilim) begin
                post(ess_pkg::ST_FAIL, 0, 0, 0);
                return;
            end
            post(ess_pkg::ST_CONTINUE, pc, 0, 0);
        endfunction

        function void check_beat(ess_pkg::out_beat_t got);
            ess_pkg::out_beat_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            case (got.status)
                ess_pkg::ST_FOUND: found_cnt++;
                ess_pkg::ST_FAIL: fail_cnt++;
                ess_pkg::ST_CONTINUE: cont_cnt++;
                default: ;
            endcase
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.fetch_address !== e.fetch_address) begin
                $error("fetch_address expected %h actual %h", e.fetch_address,
                       got.fetch_address);
                errors++;
            end
            if (got.target_address !== e.target_address) begin
                $error("target_address expected %h actual %h", e.target_address,
                       got.target_address);
                errors++;
            end
            if (got.bkpt_len !== e.bkpt_len) begin
                $error("bkpt_len expected %0d actual %0d", e.bkpt_len, got.bkpt_len);
                errors++;
            end
            if (got.instr_used !== e.instr_used) begin
                $error("instr_used expected %0d actual %0d", e.instr_used, got.instr_used);
                errors++;
            end
            if (got.bytes_used !== e.bytes_used) begin
                $error("bytes_used expected %0d actual %0d", e.bytes_used, got.bytes_used);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    ess_pkg::in_beat_t s_data;
    logic m_valid;
    logic m_ready;
    ess_pkg::out_beat_t m_data;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [8:0] cfg_data;

    scan_scoreboard sb;
    int idle_cycles;
    int beats_sent;
    int burst_left;
    bit stall_free;

    exclusive_sequence_scanner DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_beat(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver stalls: stretches with no stalls alternate with random ones.
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_free = !stall_free;
        m_ready <= stall_free ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    task automatic send_beat(ess_pkg::in_beat_t x);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 4)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_data <= x;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(x);
        beats_sent++;
        @(negedge aclk);
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == ess_pkg::REG_INSTRUCTION_LIMIT) sb.ilim = val[6:0];
        else sb.blim = val;
        @(negedge aclk);
    endtask

    task automatic drain();
        if (burst_left != 0) begin
            s_valid <= 1'b0;
            burst_left = 0;
        end
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic ess_pkg::in_beat_t start_beat(bit thumb, logic [31:0] pc);
        ess_pkg::in_beat_t x;
        x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        x.req_type = ess_pkg::REQ_START;
        x.start_pc = pc;
        x.status_word[24] = 0;
        x.status_word[9] = 0;
        x.status_word[5] = thumb;
        x.status_word[15:10] = 0;
        x.status_word[26:25] = 0;
        if ($urandom_range(0, 3) != 0) x.status_word[31:28] = 4'b0000;
        return x;
    endfunction

    function automatic ess_pkg::in_beat_t fetch_beat(logic [31:0] w);
        ess_pkg::in_beat_t x;
        x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        x.req_type = 1'b1;
        x.code_word = w;
        x.first_read_ok = ($urandom_range(0, 40) != 0);
        x.second_read_ok = ($urandom_range(0, 40) != 0);
        return x;
    endfunction

    function automatic logic [31:0] arm_load(logic [3:0] rn, logic [2:0] f);
        logic [31:0] w;
        case (f)
            ess_pkg::FAM_BYTE: w = 32'he1d00f9f;
            ess_pkg::FAM_HALF: w = 32'he1f00f9f;
            ess_pkg::FAM_DOUBLE: w = 32'he1b00f9f;
            default: w = 32'he1900f9f;
        endcase
        w[19:16] = rn;
        w[15:12] = (f == ess_pkg::FAM_DOUBLE) ? 4'(2 * $urandom_range(0, 6))
                                              : 4'($urandom_range(0, 14));
        return w;
    endfunction

    function automatic logic [31:0] arm_store(logic [3:0] rn, logic [2:0] f);
        logic [31:0] w;
        case (f)
            ess_pkg::FAM_BYTE: w = 32'he1c00f90;
            ess_pkg::FAM_HALF: w = 32'he1e00f90;
            ess_pkg::FAM_DOUBLE: w = 32'he1a00f90;
            default: w = 32'he1800f90;
        endcase
        w[19:16] = rn;
        w[15:12] = 4'($urandom_range(0, 15));
        w[3:0] = (f == ess_pkg::FAM_DOUBLE) ? 4'(2 * $urandom_range(0, 6))
                                            : 4'($urandom_range(0, 14));
        return w;
    endfunction

    function automatic logic [31:0] t_load(logic [3:0] rn, logic [2:0] f);
        logic [15:0] a, b;
        a = (f == ess_pkg::FAM_WORD) ? 16'he850 : 16'he8d0;
        a[3:0] = rn;
        b = 16'($urandom);
        case (f)
            ess_pkg::FAM_WORD: b[11:8] = 4'hf;
            ess_pkg::FAM_BYTE: b[11:0] = 12'hf4f;
            ess_pkg::FAM_HALF: b[11:0] = 12'hf5f;
            default: b[7:0] = 8'h7f;
        endcase
        b[15:12] = 4'($urandom_range(0, 12));
        return {b, a};
    endfunction

    function automatic logic [31:0] t_store(logic [3:0] rn, logic [2:0] f);
        logic [15:0] a, b;
        a = (f == ess_pkg::FAM_WORD) ? 16'he840 : 16'he8c0;
        a[3:0] = rn;
        b = 16'($urandom);
        case (f)
            ess_pkg::FAM_BYTE: b[11:4] = 8'hf4;
            ess_pkg::FAM_HALF: b[11:4] = 8'hf5;
            ess_pkg::FAM_DOUBLE: b[7:4] = 4'h7;
            default: ;
        endcase
        return {b, a};
    endfunction

    function automatic logic [31:0] filler(bit thumb);
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) < 7) begin
            if (thumb) w[15:0] = 16'h1c00 | 16'($urandom_range(0, 16'h3ff));
            else w = 32'he0800000 | ($urandom & 32'h000fffff);
        end
        return w;
    endfunction

    task automatic run_sequence(bit thumb, logic [31:0] pc, int body);
        logic [2:0] f;
        logic [3:0] rn;
        int k;
        f = 3'($urandom_range(1, 4));
        rn = 4'($urandom_range(0, 14));
        send_beat(start_beat(thumb, pc));
        send_beat(fetch_beat(thumb ? t_load(rn, f) : arm_load(rn, f)));
        for (k = 0; k < body; k++) send_beat(fetch_beat(filler(thumb)));
        case ($urandom_range(0, 5))
            0: send_beat(fetch_beat(thumb ? 32'h8f2ff3bf : 32'hf57ff01f));
            1: send_beat(fetch_beat(thumb ? t_store(4'($urandom), f) : arm_store(rn, f)));
            default: send_beat(fetch_beat(thumb ? t_store(rn, f) : arm_store(rn, f)));
        endcase
    endtask

    task automatic random_phase(int n);
        int k;
        int body;
        bit th;
        logic [31:0] pc;
        ess_pkg::in_beat_t x;
        k = 0;
        while (k < n) begin
            th = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: pc = 32'hffffffff - 4 * $urandom_range(0, 6) - (th ? 1 : 3);
                1: pc = $urandom;
                default: pc = $urandom_range(0, 32'h0fffffff);
            endcase
            pc[0] = 0;
            if (!th) pc[1] = 0;
            if ($urandom_range(0, 9) < 8) begin
                body = $urandom_range(0, 10);
                run_sequence(th, pc, body);
                k += body + 3;
            end else begin
                x = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
                send_beat(x);
                k++;
            end
        end
    endtask

    initial begin
        ess_pkg::in_beat_t x;
        int i;
        sb = new();
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        cfg_we = 0;
        cfg_index = ess_pkg::REG_INSTRUCTION_LIMIT;
        cfg_data = 0;
        idle_cycles = 0;
        beats_sent = 0;
        burst_left = 0;
        stall_free = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: idle fetch, bad starts, each ARM family, both modes, faults.
        send_beat(fetch_beat(32'h0));
        x = start_beat(0, 32'h100);
        x.status_word[24] = 1;
        send_beat(x);
        x = start_beat(0, 32'h100);
        x.status_word[9] = 1;
        send_beat(x);
        x = start_beat(1, 32'h100);
        x.status_word[12] = 1;
        send_beat(x);
        send_beat(start_beat(0, 32'h102));
        send_beat(start_beat(1, 32'h101));
        send_beat(start_beat(0, 32'hffffffff));
        for (i = 1; i <= 4; i++) begin
            send_beat(start_beat(0, 32'h1000));
            send_beat(fetch_beat(arm_load(4'd3, 3'(i))));
            send_beat(fetch_beat(arm_store(4'd3, 3'(i))));
        end
        send_beat(start_beat(1, 32'hfffffffe));
        send_beat(fetch_beat(32'h0000bf08));
        run_sequence(1, 32'hfffffff8, 2);
        run_sequence(0, 32'h0, 1);
        drain();

        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd0);
        send_beat(start_beat(0, 32'h40));
        drain();
        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd3);
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd0);
        send_beat(start_beat(0, 32'h40));
        drain();
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd6);
        random_phase(150);
        drain();
        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd1);
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd257);
        random_phase(60);
        drain();
        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd127);
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd511);
        random_phase(60);
        drain();
        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd64);
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd256);
        random_phase(ITEM_TARGET - 400);
        drain();
        write_reg(ess_pkg::REG_INSTRUCTION_LIMIT, 9'd8);
        write_reg(ess_pkg::REG_BYTE_LIMIT, 9'd20);
        random_phase(100);
        drain();
        repeat (10) @(negedge aclk);

        $display("Sent %0d beats: %0d targets found, %0d failed scans, %0d continues.",
                 beats_sent, sb.found_cnt, sb.fail_cnt, sb.cont_cnt);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/ess_pkg.sv
rtl/ess_decode.sv
rtl/exclusive_sequence_scanner.sv
dv/exclusive_sequence_scanner_test.sv
